// File: sv/mcte_pkg.sv
`timescale 1ns / 1ps

package mcte_pkg;

  typedef logic [7:0] signs_t;
  typedef logic [3:0] edge_t;
  typedef logic [2:0] face_t;
  typedef logic [2:0] corner_t;
  typedef logic [1:0] poly_t;

  localparam int NumEdges = 12;
  localparam int NumFaces = 6;

  // edge code past the last edge; marks the end of the scan and a missing successor
  localparam edge_t NO_EDGE    = 4'd12;
  localparam face_t FACE_COUNT = 3'd6;

  // corners: 0 LBN, 1 LBF, 2 LTN, 3 LTF, 4 RBN, 5 RBF, 6 RTN, 7 RTF
  // faces:   0 L, 1 R, 2 B, 3 T, 4 N, 5 F
  localparam corner_t EDGE_CA [NumEdges] = '{
    3'd0, 3'd2, 3'd0, 3'd1, 3'd4, 3'd6, 3'd4, 3'd5, 3'd0, 3'd1, 3'd2, 3'd3
  };
  localparam corner_t EDGE_CB [NumEdges] = '{
    3'd1, 3'd3, 3'd2, 3'd3, 3'd5, 3'd7, 3'd6, 3'd7, 3'd4, 3'd5, 3'd6, 3'd7
  };
  localparam face_t EDGE_LFACE [NumEdges] = '{
    3'd2, 3'd0, 3'd0, 3'd5, 3'd1, 3'd3, 3'd4, 3'd1, 3'd4, 3'd2, 3'd3, 3'd5
  };
  localparam face_t EDGE_RFACE [NumEdges] = '{
    3'd0, 3'd3, 3'd4, 3'd0, 3'd2, 3'd1, 3'd1, 3'd5, 3'd2, 3'd5, 3'd4, 3'd3
  };

  // clockwise successor of an edge on each face
  localparam edge_t EDGE_CW [NumEdges][NumFaces] = '{
    '{4'd3,  4'd12, 4'd8,  4'd12, 4'd12, 4'd12},
    '{4'd2,  4'd12, 4'd12, 4'd11, 4'd12, 4'd12},
    '{4'd0,  4'd12, 4'd12, 4'd12, 4'd10, 4'd12},
    '{4'd1,  4'd12, 4'd12, 4'd12, 4'd12, 4'd9 },
    '{4'd12, 4'd6,  4'd9,  4'd12, 4'd12, 4'd12},
    '{4'd12, 4'd7,  4'd12, 4'd10, 4'd12, 4'd12},
    '{4'd12, 4'd5,  4'd12, 4'd12, 4'd8,  4'd12},
    '{4'd12, 4'd4,  4'd12, 4'd12, 4'd12, 4'd11},
    '{4'd12, 4'd12, 4'd4,  4'd12, 4'd2,  4'd12},
    '{4'd12, 4'd12, 4'd0,  4'd12, 4'd12, 4'd7 },
    '{4'd12, 4'd12, 4'd12, 4'd1,  4'd6,  4'd12},
    '{4'd12, 4'd12, 4'd12, 4'd5,  4'd12, 4'd3 }
  };

  typedef struct packed {
    logic load;        // capture a new cube
    logic scan_adv;    // move the start pointer to the next edge
    logic walk_begin;  // open a polygon at the start edge
    logic walk_step;   // advance the walk by one edge
    logic flush;       // release the held triangle as the last one
  } cmd_t;

  typedef struct packed {
    logic start_done;  // start pointer ran past the last edge
    logic start_hit;   // start edge is crossed and not yet used
    logic tri_new;     // the next walk step completes a triangle
    logic closing;     // the next walk step returns to the start edge
    logic pend_valid;  // a triangle is held back
    logic out_free;    // output register can take a triangle this cycle
  } stat_t;

  function automatic logic edge_crossed(signs_t signs, edge_t e);
    logic crossed;
    crossed = 1'b0;
    if (e < NO_EDGE) begin
      crossed = signs[EDGE_CA[e]] ^ signs[EDGE_CB[e]];
    end
    return crossed;
  endfunction

  function automatic edge_t cw_next(edge_t e, face_t f);
    edge_t nx;
    nx = NO_EDGE;
    if (e < NO_EDGE && f < FACE_COUNT) begin
      nx = EDGE_CW[e][f];
    end
    return nx;
  endfunction

endpackage

// File: sv/mcte_ctrl.sv
`timescale 1ns / 1ps

module mcte_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  mcte_pkg::stat_t stat,
  output mcte_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    WALK,
    FLUSH
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = SCAN;
        end
      end
      SCAN: begin
        priority if (stat.start_done) begin
          state_next = FLUSH;
        end else if (stat.start_hit) begin
          cmd.walk_begin = 1'b1;
          state_next     = WALK;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      WALK: begin
        // a second triangle while one is held needs room in the output register
        if (!(stat.tri_new && stat.pend_valid && !stat.out_free)) begin
          cmd.walk_step = 1'b1;
          if (stat.closing) begin
            state_next = SCAN;
          end
        end
      end
      FLUSH: begin
        priority if (!stat.pend_valid) begin
          state_next = IDLE;
        end else if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: sv/mcte_dp.sv
`timescale 1ns / 1ps

module mcte_dp (
  input  logic              clk,
  input  logic              rst,
  input  mcte_pkg::signs_t  corner_signs,
  input  mcte_pkg::cmd_t    cmd,
  output mcte_pkg::stat_t   stat,
  output logic              out_valid,
  input  logic              out_stall,
  output mcte_pkg::edge_t   edge_newest,
  output mcte_pkg::edge_t   edge_previous,
  output mcte_pkg::edge_t   edge_anchor,
  output mcte_pkg::poly_t   polygon_number,
  output logic              last_triangle
);

  mcte_pkg::signs_t signs;
  logic [11:0]      used;
  mcte_pkg::edge_t  start;
  mcte_pkg::edge_t  cur;
  mcte_pkg::face_t  face;
  mcte_pkg::edge_t  v0;
  mcte_pkg::edge_t  vprev;
  logic [3:0]       nv;
  mcte_pkg::poly_t  poly;

  // one triangle is held back until the next one or the end shows whether it is last
  logic             pend_valid;
  mcte_pkg::edge_t  pend_newest;
  mcte_pkg::edge_t  pend_previous;
  mcte_pkg::edge_t  pend_anchor;
  mcte_pkg::poly_t  pend_poly;

  mcte_pkg::edge_t  nx;
  logic             nx_crossed;
  logic             tri_new;
  logic             out_free;
  logic             out_load;
  logic             out_valid_next;
  mcte_pkg::face_t  face_begin;
  mcte_pkg::face_t  face_after;

  assign nx         = mcte_pkg::cw_next(cur, face);
  assign nx_crossed = mcte_pkg::edge_crossed(signs, nx);
  assign tri_new    = nx_crossed && (nv >= 4'd2);
  assign out_free   = !out_valid || !out_stall;

  always_comb begin
    face_begin = '0;
    face_after = '0;
    if (start < mcte_pkg::NO_EDGE) begin
      face_begin = signs[mcte_pkg::EDGE_CA[start]] ? mcte_pkg::EDGE_RFACE[start]
                                                   : mcte_pkg::EDGE_LFACE[start];
    end
    if (nx < mcte_pkg::NO_EDGE) begin
      face_after = (mcte_pkg::EDGE_LFACE[nx] == face) ? mcte_pkg::EDGE_RFACE[nx]
                                                      : mcte_pkg::EDGE_LFACE[nx];
    end
  end

  always_comb begin
    stat.start_done = (start >= mcte_pkg::NO_EDGE);
    stat.start_hit  = (start < mcte_pkg::NO_EDGE) && !used[start]
                      && mcte_pkg::edge_crossed(signs, start);
    stat.tri_new    = tri_new;
    stat.closing    = (nx == start);
    stat.pend_valid = pend_valid;
    stat.out_free   = out_free;
  end

  assign out_load = pend_valid && ((cmd.walk_step && tri_new) || cmd.flush);
  assign out_valid_next = out_load ? 1'b1 : (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (cmd.walk_step && tri_new) begin
        pend_valid <= 1'b1;
      end else if (cmd.flush) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      signs <= corner_signs;
      used  <= '0;
      start <= '0;
      poly  <= '0;
    end
    if (cmd.scan_adv) begin
      start <= start + 4'd1;
    end
    if (cmd.walk_begin) begin
      cur  <= start;
      face <= face_begin;
      nv   <= '0;
    end
    if (cmd.walk_step) begin
      used[nx] <= 1'b1;
      cur      <= nx;
      if (nx_crossed) begin
        nv    <= nv + 4'd1;
        vprev <= nx;
        face  <= face_after;
        if (nv == 4'd0) begin
          v0 <= nx;
        end
      end
      if (tri_new) begin
        pend_newest   <= nx;
        pend_previous <= vprev;
        pend_anchor   <= v0;
        pend_poly     <= poly;
      end
      if (nx == start) begin
        poly  <= poly + 2'd1;
        start <= start + 4'd1;
      end
    end
    if (out_load) begin
      edge_newest    <= pend_newest;
      edge_previous  <= pend_previous;
      edge_anchor    <= pend_anchor;
      polygon_number <= pend_poly;
      last_triangle  <= cmd.flush;
    end
  end

endmodule

// File: sv/marching_cube_triangle_emitter.sv
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// in        input      in_valid / in_stall  corner_signs
// out       output     out_valid/out_stall  edge_newest, edge_previous, edge_anchor,
//                                           polygon_number, last_triangle
//
// one cube at a time: in_stall stays high after a cube is accepted until the controller
// is back in IDLE; every edge step of the face walk goes through one shared step unit,
// one edge a cycle unless a held triangle waits on out_stall
// each triangle is held until the next one or the cube's end, so the last can be flagged
// synchronous active-high rst clears the controller and the valid flags
// out_stall pauses the walk or the final flush only when a held triangle has nowhere to go

module marching_cube_triangle_emitter (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  mcte_pkg::signs_t    corner_signs,
  output logic                out_valid,
  input  logic                out_stall,
  output mcte_pkg::edge_t     edge_newest,
  output mcte_pkg::edge_t     edge_previous,
  output mcte_pkg::edge_t     edge_anchor,
  output mcte_pkg::poly_t     polygon_number,
  output logic                last_triangle
);

  mcte_pkg::cmd_t  cmd;
  mcte_pkg::stat_t stat;

  mcte_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mcte_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .corner_signs   (corner_signs),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .edge_newest    (edge_newest),
    .edge_previous  (edge_previous),
    .edge_anchor    (edge_anchor),
    .polygon_number (polygon_number),
    .last_triangle  (last_triangle)
  );

  // at most one command per cycle
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.scan_adv, cmd.walk_begin, cmd.walk_step, cmd.flush}))
    else $error("more than one datapath command");

  // a held triangle never overwrites a result still waiting at the output
  assert property (@(posedge clk) disable iff (rst)
    (cmd.walk_step && stat.tri_new && stat.pend_valid) || cmd.flush |-> stat.out_free)
    else $error("output register overwritten");

  // a new cube starts with nothing held back from the previous one
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> !stat.pend_valid)
    else $error("held triangle left over at cube start");

  // the flagged last triangle leaves the block with no triangle behind it
  assert property (@(posedge clk) disable iff (rst)
    cmd.flush |=> !stat.pend_valid && out_valid && last_triangle)
    else $error("last triangle not presented after flush");

endmodule

// File: bench/mcte_triangle_checker.sv
`timescale 1ns / 1ps

module mcte_triangle_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_stall,
  input  mcte_pkg::signs_t corner_signs,
  input  logic             out_valid,
  input  logic             out_stall,
  input  mcte_pkg::edge_t  edge_newest,
  input  mcte_pkg::edge_t  edge_previous,
  input  mcte_pkg::edge_t  edge_anchor,
  input  mcte_pkg::poly_t  polygon_number,
  input  logic             last_triangle,
  output int               failures,
  output int               pending,
  output int               cubes_seen,
  output int               triangles_checked
);

  localparam int MaxTriangles = 10;
  localparam int WalkLimit    = 64;

  localparam mcte_pkg::face_t FACE_L = 3'd0;
  localparam mcte_pkg::face_t FACE_R = 3'd1;
  localparam mcte_pkg::face_t FACE_B = 3'd2;
  localparam mcte_pkg::face_t FACE_T = 3'd3;
  localparam mcte_pkg::face_t FACE_N = 3'd4;
  localparam mcte_pkg::face_t FACE_F = 3'd5;
  localparam mcte_pkg::edge_t NX     = mcte_pkg::NO_EDGE;

  // edges: LB LT LN LF RB RT RN RF BN BF TN TF
  localparam mcte_pkg::corner_t END_A [12] = '{
    3'd0, 3'd2, 3'd0, 3'd1, 3'd4, 3'd6, 3'd4, 3'd5, 3'd0, 3'd1, 3'd2, 3'd3
  };
  localparam mcte_pkg::corner_t END_B [12] = '{
    3'd1, 3'd3, 3'd2, 3'd3, 3'd5, 3'd7, 3'd6, 3'd7, 3'd4, 3'd5, 3'd6, 3'd7
  };
  localparam mcte_pkg::face_t LEFT_OF [12] = '{
    FACE_B, FACE_L, FACE_L, FACE_F, FACE_R, FACE_T,
    FACE_N, FACE_R, FACE_N, FACE_B, FACE_T, FACE_F
  };
  localparam mcte_pkg::face_t RIGHT_OF [12] = '{
    FACE_L, FACE_T, FACE_N, FACE_L, FACE_B, FACE_R,
    FACE_R, FACE_F, FACE_B, FACE_F, FACE_N, FACE_T
  };
  // next edge going clockwise around a face, indexed by edge then face L R B T N F
  localparam mcte_pkg::edge_t CLOCKWISE [12][6] = '{
    '{4'd3, NX,   4'd8, NX,    NX,    NX   },
    '{4'd2, NX,   NX,   4'd11, NX,    NX   },
    '{4'd0, NX,   NX,   NX,    4'd10, NX   },
    '{4'd1, NX,   NX,   NX,    NX,    4'd9 },
    '{NX,   4'd6, 4'd9, NX,    NX,    NX   },
    '{NX,   4'd7, NX,   4'd10, NX,    NX   },
    '{NX,   4'd5, NX,   NX,    4'd8,  NX   },
    '{NX,   4'd4, NX,   NX,    NX,    4'd11},
    '{NX,   NX,   4'd4, NX,    4'd2,  NX   },
    '{NX,   NX,   4'd0, NX,    NX,    4'd7 },
    '{NX,   NX,   NX,   4'd1,  4'd6,  NX   },
    '{NX,   NX,   NX,   4'd5,  NX,    4'd3 }
  };

  typedef struct {
    mcte_pkg::edge_t newest;
    mcte_pkg::edge_t previous;
    mcte_pkg::edge_t anchor;
    mcte_pkg::poly_t polygon;
    logic            last;
  } triangle_t;

  triangle_t expected_triangles[$];

  function automatic logic sign_change(mcte_pkg::signs_t signs, int e);
    return signs[END_A[e]] ^ signs[END_B[e]];
  endfunction

  function automatic void predict_cube_triangles(mcte_pkg::signs_t signs);
    logic [11:0]     visited;
    mcte_pkg::edge_t ring[12];
    triangle_t       fan[$];
    triangle_t       t;
    int              ring_len;
    int              poly;
    int              start;
    int              steps;
    int              j;
    mcte_pkg::edge_t cur;
    mcte_pkg::edge_t nx;
    mcte_pkg::face_t face;
    logic            closed;
    visited = '0;
    poly = 0;
    for (start = 0; start < 12; start++) begin
      if (visited[start] || !sign_change(signs, start)) continue;
      cur = mcte_pkg::edge_t'(start);
      face = signs[END_A[start]] ? RIGHT_OF[start] : LEFT_OF[start];
      ring_len = 0;
      closed = 1'b0;
      for (steps = 0; steps < WalkLimit; steps++) begin
        if (face >= mcte_pkg::FACE_COUNT) break;
        nx = CLOCKWISE[cur][face];
        if (nx >= mcte_pkg::NO_EDGE) break;
        visited[nx] = 1'b1;
        cur = nx;
        if (sign_change(signs, nx)) begin
          if (ring_len < 12) begin
            ring[ring_len] = nx;
            ring_len++;
          end
          if (nx == mcte_pkg::edge_t'(start)) begin
            closed = 1'b1;
            break;
          end
          // cross over to the other face of this edge
          face = (LEFT_OF[nx] == face) ? RIGHT_OF[nx] : LEFT_OF[nx];
        end
      end
      if (!closed) continue;
      for (j = 2; j < ring_len; j++) begin
        if (fan.size() < MaxTriangles) begin
          t.newest   = ring[j];
          t.previous = ring[j-1];
          t.anchor   = ring[0];
          t.polygon  = mcte_pkg::poly_t'(poly);
          t.last     = 1'b0;
          fan.push_back(t);
        end
      end
      poly++;
    end
    if (fan.size() > 0) fan[fan.size()-1].last = 1'b1;
    foreach (fan[i]) expected_triangles.push_back(fan[i]);
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  triangle_t want;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        predict_cube_triangles(corner_signs);
        cubes_seen++;
      end
      if (out_valid && !out_stall) begin
        if (expected_triangles.size() == 0) begin
          $error("triangle transaction with nothing expected: %0d %0d %0d poly %0d last %0d",
                 edge_newest, edge_previous, edge_anchor, polygon_number, last_triangle);
          failures++;
        end else begin
          want = expected_triangles.pop_front();
          check_field("edge_newest", want.newest, edge_newest);
          check_field("edge_previous", want.previous, edge_previous);
          check_field("edge_anchor", want.anchor, edge_anchor);
          check_field("polygon_number", want.polygon, polygon_number);
          check_field("last_triangle", want.last, last_triangle);
          triangles_checked++;
        end
      end
      pending = expected_triangles.size();
    end
  end

endmodule

// File: bench/tb_marching_cube_triangle_emitter.sv
`timescale 1ns / 1ps

module tb_marching_cube_triangle_emitter;

  localparam int RandomItems = 450;
  localparam int PhaseItems  = 113;
  localparam int SettleTime  = 64;
  localparam int CycleLimit  = 1000000;

  localparam int SEND_IDLE  [4] = '{0, 83, 0, 20};
  localparam int RECV_STALL [4] = '{0, 0, 83, 20};

  // uniform, single corners, two of their complements, two-polygon and multi-polygon patterns
  localparam mcte_pkg::signs_t DIRECTED_CUBES [21] = '{
    8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
    8'hFE, 8'h7F, 8'h81, 8'h0F, 8'h69, 8'h96, 8'h3C, 8'h5A, 8'h17, 8'hE8, 8'h33
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  mcte_pkg::signs_t corner_signs = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  mcte_pkg::edge_t  edge_newest;
  mcte_pkg::edge_t  edge_previous;
  mcte_pkg::edge_t  edge_anchor;
  mcte_pkg::poly_t  polygon_number;
  logic             last_triangle;

  int failures;
  int pending;
  int cubes_seen;
  int triangles_checked;
  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_count = 0;

  marching_cube_triangle_emitter DUT (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .corner_signs   (corner_signs),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .edge_newest    (edge_newest),
    .edge_previous  (edge_previous),
    .edge_anchor    (edge_anchor),
    .polygon_number (polygon_number),
    .last_triangle  (last_triangle)
  );

  mcte_triangle_checker checker_i (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .corner_signs      (corner_signs),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .edge_newest       (edge_newest),
    .edge_previous     (edge_previous),
    .edge_anchor       (edge_anchor),
    .polygon_number    (polygon_number),
    .last_triangle     (last_triangle),
    .failures          (failures),
    .pending           (pending),
    .cubes_seen        (cubes_seen),
    .triangles_checked (triangles_checked)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic send_cube(mcte_pkg::signs_t s);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    corner_signs <= s;
    do @(posedge clk); while (in_stall);
  endtask

  // hold the input off until every triangle in flight has come out
  task automatic drain_triangles();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int perm[256];
    int i;
    int j;
    int tmp;
    int n;
    for (i = 0; i < 256; i++) perm[i] = i;
    for (i = 255; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED_CUBES[k]) send_cube(DIRECTED_CUBES[k]);

    // every sign pattern once in shuffled order, then uniform random patterns
    for (n = 0; n < RandomItems; n++) begin
      if (n % PhaseItems == 0) begin
        drain_triangles();
        idle_pct  = SEND_IDLE[n / PhaseItems];
        stall_pct = RECV_STALL[n / PhaseItems];
      end
      send_cube(n < 256 ? mcte_pkg::signs_t'(perm[n])
                        : mcte_pkg::signs_t'($urandom_range(0, 255)));
    end

    drain_triangles();
    repeat (SettleTime) @(posedge clk);

    $display("summary: %0d cubes sent, all 256 sign patterns among them, %0d triangles checked",
             cubes_seen, triangles_checked);
    $display("summary: phases ran with free flow, sparse input, heavy output stall, both mixed");
    if (failures == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/mcte_pkg.sv
sv/mcte_ctrl.sv
sv/mcte_dp.sv
sv/marching_cube_triangle_emitter.sv
bench/mcte_triangle_checker.sv
bench/tb_marching_cube_triangle_emitter.sv
